@@ src/dhmf_pkg.sv @@
// ----------------------------------------------------------------------------
// dhmf_pkg
// Shared constants, types and helper functions of the depth hole median filter.
// ----------------------------------------------------------------------------
package dhmf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MAX_WINDOW = 7;
    localparam int RING_ROWS  = MAX_WINDOW + 1;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int RING_W  = $clog2(RING_ROWS);
    localparam int ADDR_W  = RING_W + COL_W;
    localparam int MEM_DEPTH = RING_ROWS * MAX_WIDTH;
    localparam int DIM_W   = 11;
    localparam int SIZE_W  = 3;
    localparam int PIX_W   = 8;
    localparam int NCELL   = MAX_WINDOW * MAX_WINDOW;
    localparam int CNT_W   = $clog2(NCELL + 1);
    localparam int SVAL_W  = PIX_W + 1;

    // An empty sorter cell holds a value above every pixel.
    localparam logic [SVAL_W-1:0] SVAL_EMPTY = SVAL_W'(1 << PIX_W);

    localparam logic [1:0] REG_WINDOW_SIZE    = 2'd0;
    localparam logic [1:0] REG_HOLE_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_FRAME_WIDTH    = 2'd2;
    localparam logic [1:0] REG_FRAME_HEIGHT   = 2'd3;

    localparam logic [SIZE_W-1:0] RST_WINDOW_SIZE  = 3'd3;
    localparam logic [PIX_W-1:0]  RST_THRESHOLD    = 8'd0;
    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 11'd640;
    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 11'd480;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CENTER,
        S_CHECK,
        S_WIN,
        S_LAST,
        S_POP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              clr;
        logic              ins;
        logic              shift;
        logic [SVAL_W-1:0] value;
    } t_cell_ctl;

    function automatic logic [SIZE_W-1:0] bound_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0) r = SIZE_W'(1);
        else if (v > SIZE_W'(MAX_WINDOW)) r = SIZE_W'(MAX_WINDOW);
        else r = v;
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] bound_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] top);
        logic [DIM_W-1:0] r;
        if (v == '0) r = DIM_W'(1);
        else if (v > top) r = top;
        else r = v;
        return r;
    endfunction

    // Index of the upper middle element of a size x size window.
    function automatic logic [CNT_W-1:0] half_count(input logic [SIZE_W-1:0] s);
        logic [2*SIZE_W-1:0] n;
        n = s * s;
        return CNT_W'(n >> 1);
    endfunction

endpackage

@@ src/depth_hole_median_filter_unit.sv @@
// ----------------------------------------------------------------------------
// depth_hole_median_filter_unit
// Switching median filter that fills holes in an 8-bit depth pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter on the slave stream (tdata = pixel, tuser = 1 for a drain word)
// in raster order and are kept in an eight-row ring of line stores. Each word
// that completes a result's window sends one result to the master stream
// (tdata = pixel, tuser = filled flag, tlast = final pixel of the frame).
// The configuration channel writes window size, hole threshold, frame width
// and frame height; they are sampled at the first pixel of every frame.
// One word is processed at a time; a word with no result keeps it idle.
// A passed-through pixel goes through the center read and threshold check
// states to the output state, which loads it into the output register; the
// next word is taken after that. A filled pixel takes one line store read
// per window pixel into the sorting chain, then one shift per rank up to
// the median.
// After the last pixel of a frame, drain words flush the remaining results.
// Reset clears all counters and control state; the line stores are not
// cleared. When the receiver stalls, the result waits in the output register
// while the next word is still taken; the block holds only when a second
// result is ready before the first has left.
// ----------------------------------------------------------------------------
module depth_hole_median_filter_unit import dhmf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [PIX_W-1:0] i_s_tdata,   // [7:0] depth_pixel
    input  logic             i_s_tuser,   // [0] cmd
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [PIX_W-1:0] o_m_tdata,   // [7:0] out_pixel
    output logic             o_m_tuser,   // [0] was_filled
    output logic             o_m_tlast,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [DIM_W-1:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [SIZE_W-1:0] r_cfg_size;
    logic [PIX_W-1:0]  r_cfg_thr;
    logic [DIM_W-1:0]  r_cfg_w, r_cfg_h;
    logic [SIZE_W-1:0] r_cur_size;
    logic [PIX_W-1:0]  r_cur_thr;
    logic [DIM_W-1:0]  r_cur_w, r_cur_h;

    logic [COL_W-1:0]  r_in_col, r_out_col;
    logic [ROW_W-1:0]  r_in_row, r_out_row;
    logic              r_draining;

    logic [SIZE_W-1:0] r_fy, r_fx;
    logic              r_feed;
    logic [CNT_W-1:0]  r_k;
    logic [PIX_W-1:0]  r_lo;
    logic [PIX_W-1:0]  r_res;
    logic              r_filled;

    logic              r_out_valid;
    logic [PIX_W-1:0]  r_out_pixel;
    logic              r_out_filled, r_out_last;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_size <= RST_WINDOW_SIZE;
            r_cfg_thr  <= RST_THRESHOLD;
            r_cfg_w    <= RST_FRAME_WIDTH;
            r_cfg_h    <= RST_FRAME_HEIGHT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WINDOW_SIZE:    r_cfg_size <= i_cfg_data[SIZE_W-1:0];
                REG_HOLE_THRESHOLD: r_cfg_thr  <= i_cfg_data[PIX_W-1:0];
                REG_FRAME_WIDTH:    r_cfg_w    <= i_cfg_data;
                REG_FRAME_HEIGHT:   r_cfg_h    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input word decode
    // ------------------------------------------------------------------
    logic              w_accept, w_first, w_pixel;
    logic [SIZE_W-1:0] w_eff_size, w_eff_lo, w_eff_hi;
    logic [DIM_W-1:0]  w_eff_w, w_eff_h;
    logic [DIM_W-1:0]  w_eff_orow, w_eff_ocol;
    logic [DIM_W-1:0]  w_req_r_raw, w_req_c_raw, w_req_r, w_req_c;
    logic [DIM_W-1:0]  w_col_inc, w_row_inc;
    logic              w_col_wrap, w_frame_end, w_emit_now;

    assign w_accept = i_s_tvalid && o_s_tready;
    assign w_pixel  = w_accept && !r_draining && !i_s_tuser;
    assign w_first  = (r_in_row == '0) && (r_in_col == '0);

    always_comb begin
        w_eff_size = w_first ? bound_size(r_cfg_size) : r_cur_size;
        w_eff_w    = w_first ? bound_dim(r_cfg_w, DIM_W'(MAX_WIDTH)) : r_cur_w;
        w_eff_h    = w_first ? bound_dim(r_cfg_h, DIM_W'(MAX_HEIGHT)) : r_cur_h;
        w_eff_orow = w_first ? '0 : DIM_W'(r_out_row);
        w_eff_ocol = w_first ? '0 : DIM_W'(r_out_col);
        w_eff_lo   = (w_eff_size - SIZE_W'(1)) >> 1;
        w_eff_hi   = w_eff_size - SIZE_W'(1) - w_eff_lo;

        // Position of the last input the oldest pending result still needs.
        w_req_r_raw = w_eff_orow + DIM_W'(w_eff_hi);
        w_req_c_raw = w_eff_ocol + DIM_W'(w_eff_hi);
        w_req_r = (w_req_r_raw > w_eff_h - DIM_W'(1)) ? w_eff_h - DIM_W'(1) : w_req_r_raw;
        w_req_c = (w_req_c_raw > w_eff_w - DIM_W'(1)) ? w_eff_w - DIM_W'(1) : w_req_c_raw;

        w_col_inc   = DIM_W'(r_in_col) + DIM_W'(1);
        w_row_inc   = DIM_W'(r_in_row) + DIM_W'(1);
        w_col_wrap  = w_col_inc >= w_eff_w;
        w_frame_end = w_col_wrap && (w_row_inc >= w_eff_h);
        w_emit_now  = w_frame_end || (DIM_W'(r_in_row) > w_req_r)
                   || ((DIM_W'(r_in_row) == w_req_r) && (DIM_W'(r_in_col) >= w_req_c));
    end

    // ------------------------------------------------------------------
    // Window address generation
    // ------------------------------------------------------------------
    logic [SIZE_W-1:0] w_cur_lo;
    logic [DIM_W:0]    w_wrow_s, w_wcol_s;
    logic [DIM_W-1:0]  w_wrow, w_wcol;
    logic              w_win_end;
    logic [ADDR_W-1:0] w_raddr, w_waddr;
    logic [PIX_W-1:0]  w_rdata;

    always_comb begin
        w_cur_lo = (r_cur_size - SIZE_W'(1)) >> 1;
        w_wrow_s = (DIM_W+1)'(r_out_row) + (DIM_W+1)'(r_fy) - (DIM_W+1)'(w_cur_lo);
        w_wcol_s = (DIM_W+1)'(r_out_col) + (DIM_W+1)'(r_fx) - (DIM_W+1)'(w_cur_lo);
        // Borders are replicated: clamp into the frame.
        if (w_wrow_s[DIM_W]) w_wrow = '0;
        else if (w_wrow_s[DIM_W-1:0] >= r_cur_h) w_wrow = r_cur_h - DIM_W'(1);
        else w_wrow = w_wrow_s[DIM_W-1:0];
        if (w_wcol_s[DIM_W]) w_wcol = '0;
        else if (w_wcol_s[DIM_W-1:0] >= r_cur_w) w_wcol = r_cur_w - DIM_W'(1);
        else w_wcol = w_wcol_s[DIM_W-1:0];
    end

    assign w_win_end = (r_fx == r_cur_size - SIZE_W'(1)) && (r_fy == r_cur_size - SIZE_W'(1));
    assign w_waddr   = {r_in_row[RING_W-1:0], r_in_col};

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------
    logic w_out_free, w_load, w_last;
    logic [CNT_W-1:0]  w_mid;
    logic              w_odd;
    logic [SVAL_W-1:0] w_head;
    logic [PIX_W:0]    w_pair;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_load     = (r_state == S_OUT) && w_out_free;
    assign w_last     = (DIM_W'(r_out_row) == r_cur_h - DIM_W'(1))
                     && (DIM_W'(r_out_col) == r_cur_w - DIM_W'(1));
    assign w_mid      = half_count(r_cur_size);
    assign w_odd      = r_cur_size[0];
    assign w_pair     = (PIX_W+1)'(r_lo) + (PIX_W+1)'(w_head[PIX_W-1:0]);

    // ------------------------------------------------------------------
    // Control: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (r_draining || (!i_s_tuser && w_emit_now))) begin
                    n_state = S_CENTER;
                end
            end
            S_CENTER: n_state = S_CHECK;
            S_CHECK:  n_state = (w_rdata > r_cur_thr) ? S_OUT : S_WIN;
            S_WIN:    n_state = w_win_end ? S_LAST : S_WIN;
            S_LAST:   n_state = S_POP;
            S_POP:    n_state = (r_k == w_mid) ? S_OUT : S_POP;
            S_OUT:    n_state = w_out_free ? S_IDLE : S_OUT;
            default:  n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Control: outputs
    // ------------------------------------------------------------------
    t_cell_ctl w_ctl;

    always_comb begin
        o_s_tready  = 1'b0;
        w_raddr     = {w_wrow[RING_W-1:0], w_wcol[COL_W-1:0]};
        w_ctl.clr   = 1'b0;
        w_ctl.ins   = r_feed;
        w_ctl.shift = 1'b0;
        w_ctl.value = SVAL_W'(w_rdata);
        unique case (r_state)
            S_IDLE:   o_s_tready = 1'b1;
            S_CENTER: w_raddr = {r_out_row[RING_W-1:0], r_out_col};
            S_CHECK:  w_ctl.clr = (w_rdata <= r_cur_thr);
            S_POP:    w_ctl.shift = 1'b1;
            default: ;
        endcase
    end

    dhmf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MEM_DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (w_pixel),
        .i_waddr (w_waddr),
        .i_wdata (i_s_tdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    dhmf_sorter u_sorter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_head  (w_head)
    );

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur_size  <= bound_size(RST_WINDOW_SIZE);
            r_cur_thr   <= RST_THRESHOLD;
            r_cur_w     <= RST_FRAME_WIDTH;
            r_cur_h     <= RST_FRAME_HEIGHT;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_draining  <= 1'b0;
            r_fy        <= '0;
            r_fx        <= '0;
            r_feed      <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_feed  <= (r_state == S_WIN);

            if (w_pixel) begin
                if (w_first) begin
                    r_cur_size <= w_eff_size;
                    r_cur_thr  <= r_cfg_thr;
                    r_cur_w    <= w_eff_w;
                    r_cur_h    <= w_eff_h;
                    r_out_col  <= '0;
                    r_out_row  <= '0;
                end
                if (w_col_wrap) begin
                    r_in_col <= '0;
                    r_in_row <= w_frame_end ? '0 : w_row_inc[ROW_W-1:0];
                end else begin
                    r_in_col <= w_col_inc[COL_W-1:0];
                end
                r_draining <= w_frame_end;
            end

            if (r_state == S_CHECK) begin
                r_fy <= '0;
                r_fx <= '0;
                r_k  <= '0;
            end
            if (r_state == S_WIN) begin
                if (r_fx == r_cur_size - SIZE_W'(1)) begin
                    r_fx <= '0;
                    r_fy <= r_fy + SIZE_W'(1);
                end else begin
                    r_fx <= r_fx + SIZE_W'(1);
                end
            end
            if (r_state == S_POP) begin
                r_k <= r_k + CNT_W'(1);
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
                if (w_last) begin
                    r_out_col  <= '0;
                    r_out_row  <= '0;
                    r_draining <= 1'b0;
                end else if (DIM_W'(r_out_col) + DIM_W'(1) >= r_cur_w) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + ROW_W'(1);
                end else begin
                    r_out_col <= r_out_col + COL_W'(1);
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CHECK) begin
            r_res    <= w_rdata;
            r_filled <= (w_rdata <= r_cur_thr);
        end
        if (r_state == S_POP) begin
            // The head walks through the ranks; the rank below the middle
            // is kept for the even-count average.
            if (r_k == w_mid) begin
                r_res <= w_odd ? w_head[PIX_W-1:0] : w_pair[PIX_W:1];
            end else begin
                r_lo <= w_head[PIX_W-1:0];
            end
        end
        if (w_load) begin
            r_out_pixel  <= r_res;
            r_out_filled <= r_filled;
            r_out_last   <= w_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_pixel;
    assign o_m_tuser  = r_out_filled;
    assign o_m_tlast  = r_out_last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pixel |-> (r_state == S_IDLE))
        else $error("line store written outside idle");

    a_pop_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |-> (r_k <= w_mid))
        else $error("median rank counter overran");

    a_last_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_last) |=> !r_draining)
        else $error("drain state left set after frame end");

    a_win_feeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAST) |-> r_feed)
        else $error("final window read not fed to sorter");

endmodule

@@ src/dhmf_ram.sv @@
// ----------------------------------------------------------------------------
// dhmf_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dhmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/dhmf_cell.sv @@
// ----------------------------------------------------------------------------
// dhmf_cell
// One cell of the insertion sorting chain: holds one value in ascending order.
// ----------------------------------------------------------------------------
module dhmf_cell import dhmf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [SVAL_W-1:0] i_prev_val,
    input  logic              i_prev_gt,
    input  logic [SVAL_W-1:0] i_next_val,
    output logic [SVAL_W-1:0] o_val,
    output logic              o_gt
);

    logic [SVAL_W-1:0] r_val;
    logic [SVAL_W-1:0] n_val;

    assign o_gt = r_val > i_ctl.value;

    always_comb begin
        n_val = r_val;
        if (i_ctl.clr) begin
            n_val = SVAL_EMPTY;
        end else if (i_ctl.ins) begin
            // The new value lands in the first cell larger than it; the
            // cells after that take their left neighbor's value.
            if (o_gt) begin
                n_val = i_prev_gt ? i_prev_val : i_ctl.value;
            end
        end else if (i_ctl.shift) begin
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= SVAL_EMPTY;
        end else begin
            r_val <= n_val;
        end
    end

    assign o_val = r_val;

endmodule

@@ src/dhmf_sorter.sv @@
// ----------------------------------------------------------------------------
// dhmf_sorter
// Row of sorting cells; after the window is inserted it shifts out smallest first.
// ----------------------------------------------------------------------------
module dhmf_sorter import dhmf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    output logic [SVAL_W-1:0] o_head
);

    logic [SVAL_W-1:0] w_val [0:NCELL-1];
    logic              w_gt  [0:NCELL-1];

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        logic [SVAL_W-1:0] w_prev_val;
        logic              w_prev_gt;
        logic [SVAL_W-1:0] w_next_val;

        if (g == 0) begin : g_first
            assign w_prev_val = SVAL_EMPTY;
            assign w_prev_gt  = 1'b0;
        end else begin : g_mid
            assign w_prev_val = w_val[g-1];
            assign w_prev_gt  = w_gt[g-1];
        end

        if (g == NCELL - 1) begin : g_end
            assign w_next_val = SVAL_EMPTY;
        end else begin : g_inner
            assign w_next_val = w_val[g+1];
        end

        dhmf_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (i_ctl),
            .i_prev_val (w_prev_val),
            .i_prev_gt  (w_prev_gt),
            .i_next_val (w_next_val),
            .o_val      (w_val[g]),
            .o_gt       (w_gt[g])
        );
    end

    assign o_head = w_val[0];

endmodule

@@ sim/tb_depth_hole_median_filter_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_depth_hole_median_filter_unit
// Self-checking bench for the depth hole median filter. A behavioral model of
// the filter predicts every output word. Input words are sent in random
// bursts, the output side stalls on its own pattern, and the predictions are
// compared field by field.
// ----------------------------------------------------------------------------
module tb_depth_hole_median_filter_unit;
    import dhmf_pkg::*;

    typedef struct packed {
        logic [7:0] pix;
        logic       filled;
        logic       last;
    } t_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_tvalid;
    logic             o_s_tready;
    logic [7:0]       i_s_tdata;
    logic             i_s_tuser;
    logic             o_m_tvalid;
    logic             i_m_tready;
    logic [7:0]       o_m_tdata;
    logic             o_m_tuser;
    logic             o_m_tlast;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [1:0]       i_cfg_index;
    logic [DIM_W-1:0] i_cfg_data;

    depth_hole_median_filter_unit uut (.*);

    // Model state.
    logic [7:0] mdl_mem [0:RING_ROWS*MAX_WIDTH-1];
    int  in_col, in_row, out_col, out_row;
    bit  flushing;
    int  reg_size, reg_thr, reg_w, reg_h;
    int  cur_size, cur_thr, cur_w, cur_h;

    t_result pending_q[$];
    int  errors;
    int  idle_cycles;
    bit  hold_off;
    bit  stall_on;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int clip(int v, int top);
        if (v == 0) return 1;
        return (v > top) ? top : v;
    endfunction

    function automatic int clamp_idx(int v, int n);
        if (v < 0) return 0;
        if (v >= n) return n - 1;
        return v;
    endfunction

    function automatic logic [7:0] mem_at(int r, int c);
        return mdl_mem[(r % RING_ROWS) * MAX_WIDTH + (c % MAX_WIDTH)];
    endfunction

    task automatic produce_result();
        logic [7:0] win [$];
        logic [7:0] ctr;
        t_result    res;
        int         lo, n;
        ctr = mem_at(out_row, out_col);
        res.pix = ctr;
        res.filled = 1'b0;
        if (ctr <= cur_thr) begin
            lo = (cur_size - 1) / 2;
            for (int fy = 0; fy < cur_size; fy++)
                for (int fx = 0; fx < cur_size; fx++)
                    win.push_back(mem_at(clamp_idx(out_row + fy - lo, cur_h),
                                         clamp_idx(out_col + fx - lo, cur_w)));
            win.sort();
            n = win.size();
            if (n % 2) res.pix = win[n/2];
            else res.pix = 8'((int'(win[n/2]) + int'(win[n/2-1])) / 2);
            res.filled = 1'b1;
        end
        res.last = (out_row == cur_h - 1 && out_col == cur_w - 1);
        pending_q.push_back(res);
        if (res.last) begin
            out_row = 0;
            out_col = 0;
            flushing = 0;
        end else begin
            out_col++;
            if (out_col >= cur_w) begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    task automatic predict_word(bit drain, logic [7:0] pix);
        int wr, wc, hi, rr, rc;
        if (flushing) begin
            produce_result();
            return;
        end
        if (drain) return;
        if (in_row == 0 && in_col == 0) begin
            cur_size = clip(reg_size, MAX_WINDOW);
            cur_thr  = reg_thr;
            cur_w    = clip(reg_w, MAX_WIDTH);
            cur_h    = clip(reg_h, MAX_HEIGHT);
            out_row = 0;
            out_col = 0;
        end
        mdl_mem[(in_row % RING_ROWS) * MAX_WIDTH + (in_col % MAX_WIDTH)] = pix;
        wr = in_row;
        wc = in_col;
        in_col++;
        if (in_col >= cur_w) begin
            in_col = 0;
            in_row++;
            if (in_row >= cur_h) begin
                in_row = 0;
                flushing = 1;
            end
        end
        hi = cur_size - 1 - (cur_size - 1) / 2;
        rr = (out_row + hi > cur_h - 1) ? cur_h - 1 : out_row + hi;
        rc = (out_col + hi > cur_w - 1) ? cur_w - 1 : out_col + hi;
        if (flushing || wr > rr || (wr == rr && wc >= rc)) produce_result();
    endtask

    // One input word; the sender idles randomly between bursts. The valid
    // line stays high between words of one burst.
    int burst_left;
    task automatic send_word(bit drain, logic [7:0] pix);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= pix;
        i_s_tuser  <= drain;
        do @(posedge i_clk); while (!o_s_tready);
        predict_word(drain, pix);
        @(negedge i_clk);
    endtask

    task automatic wait_quiet();
        i_s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int val);
        wait_quiet();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= DIM_W'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_WINDOW_SIZE:    reg_size = val & 7;
            REG_HOLE_THRESHOLD: reg_thr  = val & 8'hff;
            REG_FRAME_WIDTH:    reg_w    = val & 11'h7ff;
            default:            reg_h    = val & 11'h7ff;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(int size, int thr, int w, int h);
        write_reg(REG_WINDOW_SIZE, size);
        write_reg(REG_HOLE_THRESHOLD, thr);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // A frame with holes and drain words at the given rates, then flush words.
    task automatic run_frame(int hole_pct, int junk_pct);
        int n;
        n = clip(reg_w, MAX_WIDTH) * clip(reg_h, MAX_HEIGHT);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < junk_pct) send_word(1'b1, 8'($urandom));
            if ($urandom_range(0, 99) < hole_pct)
                send_word(1'b0, 8'($urandom_range(0, reg_thr)));
            else send_word(1'b0, 8'($urandom));
        end
        while (flushing) send_word($urandom_range(0, 3) != 0, 8'($urandom));
        send_word(1'b1, 8'($urandom));
    endtask

    task automatic test_extremes();
        set_frame(1, 255, 1, 1);
        send_word(1'b0, 8'h00);
        send_word(1'b1, 8'h00);
        set_frame(7, 255, 3, 3);
        send_word(1'b0, 8'hff);
        send_word(1'b1, 8'h00);
        for (int k = 0; k < 8; k++) send_word(1'b0, (k % 2) ? 8'hff : 8'h00);
        send_word(1'b0, 8'h55);
        while (flushing) send_word(1'b0, 8'haa);
        send_word(1'b1, 8'h00);
    endtask

    task automatic test_even_windows();
        set_frame(2, 128, 4, 3);
        run_frame(50, 10);
        set_frame(4, 200, 5, 4);
        run_frame(50, 5);
    endtask

    task automatic test_backpressure();
        set_frame(3, 100, 8, 4);
        hold_off = 1;
        run_frame(40, 0);
    endtask

    task automatic test_random();
        int sz;
        for (int f = 0; f < 20; f++) begin
            sz = $urandom_range(0, 7);
            set_frame(sz, $urandom_range(0, 255), $urandom_range(1, 9),
                      $urandom_range(1, 6));
            run_frame($urandom_range(0, 60), $urandom_range(0, 10));
        end
        // Zero settings are clipped by the block.
        set_frame(0, 255, 0, 0);
        run_frame(50, 0);
        set_frame(5, 90, 12, 1);
        run_frame(50, 0);
        set_frame(6, 90, 2, 12);
        run_frame(30, 0);
        set_frame(3, 0, 640, 480);
    endtask

    // Receiver stall pattern, plus one long hold-off when requested.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_off) begin
            i_m_tready <= 1'b0;
        end else begin
            stall_on <= ($urandom_range(0, 63) == 0) ? ~stall_on : stall_on;
            i_m_tready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
        end
    end

    initial begin
        hold_off = 1'b0;
        wait (hold_off);
        repeat (300) @(negedge i_clk);
        hold_off = 1'b0;
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected word pix=%h filled=%b last=%b", $time,
                         o_m_tdata, o_m_tuser, o_m_tlast);
                errors++;
            end else begin
                want = pending_q.pop_front();
                if (want.pix !== o_m_tdata || want.filled !== o_m_tuser ||
                    want.last !== o_m_tlast) begin
                    $display("%0t: mismatch expected pix=%h filled=%b last=%b, got pix=%h filled=%b last=%b",
                             $time, want.pix, want.filled, want.last,
                             o_m_tdata, o_m_tuser, o_m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("tb_depth_hole_median_filter_unit: FAIL");
            $finish;
        end
    end

    initial begin
        burst_left = 0;
        in_col = 0; in_row = 0; out_col = 0; out_row = 0;
        flushing = 0;
        reg_size = 3; reg_thr = 0; reg_w = 640; reg_h = 480;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_WINDOW_SIZE;
        i_cfg_data = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_extremes();
        test_even_windows();
        test_backpressure();
        test_random();
        wait_quiet();
        if (errors == 0) $display("tb_depth_hole_median_filter_unit: PASS");
        else $display("tb_depth_hole_median_filter_unit: FAIL");
        $finish;
    end

endmodule

@@ depth_hole_median_filter_unit.f @@
src/dhmf_pkg.sv
src/dhmf_ram.sv
src/dhmf_cell.sv
src/dhmf_sorter.sv
src/depth_hole_median_filter_unit.sv
sim/tb_depth_hole_median_filter_unit.sv
